/* rtl/core/octspi_pkg.sv */
// Shared types, constants and register map of the octal serial flash controller.
`timescale 1ns / 1ps
`default_nettype none
package octspi_pkg;

  localparam int WINDOW_ADDR_BITS_DEF = 29;
  localparam int MAX_ACCESS_BYTES_DEF = 8;
  localparam int QDEPTH = 2;

  localparam logic [1:0] MODE_REG_RD = 2'd0;
  localparam logic [1:0] MODE_REG_WR = 2'd1;
  localparam logic [1:0] MODE_WIN_RD = 2'd2;
  localparam logic [1:0] MODE_WIN_WR = 2'd3;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DUMMY = 2'd1;
  localparam logic [1:0] KIND_RESP  = 2'd2;

  localparam logic [28:0] REG_CR      = 29'h00;
  localparam logic [28:0] REG_MR      = 29'h04;
  localparam logic [28:0] REG_RDR     = 29'h08;
  localparam logic [28:0] REG_TDR     = 29'h0c;
  localparam logic [28:0] REG_SR      = 29'h10;
  localparam logic [28:0] REG_IER     = 29'h14;
  localparam logic [28:0] REG_IDR     = 29'h18;
  localparam logic [28:0] REG_IMR     = 29'h1c;
  localparam logic [28:0] REG_SCFG    = 29'h20;
  localparam logic [28:0] REG_SR2     = 29'h24;
  localparam logic [28:0] REG_IAR     = 29'h30;
  localparam logic [28:0] REG_WICR    = 29'h34;
  localparam logic [28:0] REG_IFR     = 29'h38;
  localparam logic [28:0] REG_RICR    = 29'h3c;
  localparam logic [28:0] REG_SMR     = 29'h40;
  localparam logic [28:0] REG_SKR     = 29'h44;
  localparam logic [28:0] REG_REFRESH = 29'h50;
  localparam logic [28:0] REG_WRACNT  = 29'h54;
  localparam logic [28:0] REG_TOUT    = 29'h64;
  localparam logic [28:0] REG_WPMR    = 29'he4;
  localparam logic [28:0] REG_WPSR    = 29'he8;

  localparam logic [17:0] ST_RDRF    = 18'h00001;
  localparam logic [17:0] ST_TDRE    = 18'h00002;
  localparam logic [17:0] ST_TXEMPTY = 18'h00004;
  localparam logic [17:0] ST_CSR     = 18'h00100;
  localparam logic [17:0] ST_INSTRE  = 18'h00400;
  localparam logic [17:0] ST_LWRA    = 18'h00800;
  localparam logic [17:0] ST_CSFA    = 18'h04000;
  localparam logic [17:0] ST_CSRA    = 18'h08000;
  localparam logic [17:0] ST_RFRSHD  = 18'h10000;
  localparam logic [17:0] ST_TOUT    = 18'h20000;
  localparam logic [17:0] ST_ALL     = 18'h3fd0f;
  localparam logic [17:0] ST_RDCLR   = 18'h3f500;

  localparam int FR_INSTEN = 4;
  localparam int FR_ADDREN = 5;
  localparam int FR_OPTEN  = 6;
  localparam int FR_DATAEN = 7;
  localparam int FR_DDREN  = 15;
  localparam int FR_APBRD  = 24;

  localparam logic [31:0] MR_MASK   = 32'hffff2fbd;
  localparam logic [31:0] SCFG_MASK = 32'h00ffff03;
  localparam logic [31:0] IFR_MASK  = 32'h7fffdfff;
  localparam logic [23:0] WP_KEY    = 24'h515350;

  typedef enum logic [2:0] {
    OP_REG_RD, OP_REG_WR, OP_CTRL, OP_DATA, OP_WIN_RD, OP_WIN_WR, OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [28:0] addr;
    logic [63:0] wdata;
    logic [63:0] rx;
    logic [3:0]  n;
    logic [31:0] off;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_OPEN, S_IHI, S_INSTR, S_ADDR, S_OPT, S_DUMMY,
    S_WORD, S_DATA, S_FINAL
  } state_t;

  typedef struct packed {
    logic [17:0] status;
    logic        cs;
    logic        active;
    logic [31:0] count;
  } xfer_t;

  typedef struct packed {
    logic [31:0] mode_reg;
    logic [17:0] int_mask;
    logic [31:0] scramble_cfg;
    logic [31:0] instr_address;
    logic [23:0] write_instr_code;
    logic [30:0] instr_frame;
    logic [23:0] read_instr_code;
    logic [2:0]  scramble_mode;
    logic [31:0] scramble_key;
    logic [31:0] refresh_reg;
    logic [31:0] write_access_limit;
    logic [15:0] timeout_reg;
    logic [2:0]  protect_mode;
    logic [15:0] protect_status;
    logic [15:0] receive_data;
    logic        enabled;
    logic        is_write;
    logic [31:0] next_address;
  } regs_t;

  function automatic xfer_t end_xfer(xfer_t x);
    xfer_t r;
    r = x;
    if (x.active || x.cs) begin
      r.status = r.status | ST_INSTRE;
      if (x.cs) begin
        r.cs = 1'b0;
        r.status = r.status | ST_CSR | ST_CSRA;
      end
    end
    r.active = 1'b0;
    r.count = '0;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/octspi_front.sv */
// Request front end: accepts bus requests and classifies them for the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module octspi_front import octspi_pkg::*; #(
  parameter int WINDOW_ADDR_BITS = WINDOW_ADDR_BITS_DEF,
  parameter int MAX_ACCESS_BYTES = MAX_ACCESS_BYTES_DEF
) (
  input  wire logic [1:0]  mode,
  input  wire logic [28:0] addr,
  input  wire logic [63:0] wdata,
  input  wire logic [3:0]  size,
  input  wire logic [63:0] rx_data,
  output item_t            item
);
  localparam logic [63:0] WIN_MASK = (64'd1 << WINDOW_ADDR_BITS) - 64'd1;
  localparam logic [3:0]  MAXN = 4'(MAX_ACCESS_BYTES);

  logic [63:0] off_full;

  assign off_full = {35'd0, addr} & WIN_MASK;

  always_comb begin
    item.addr  = addr;
    item.wdata = wdata;
    item.rx    = rx_data;
    item.off   = off_full[31:0];
    item.n     = (size > MAXN) ? MAXN : size;
    unique case (mode)
      MODE_REG_RD: item.op = OP_REG_RD;
      MODE_REG_WR: begin
        if (addr == REG_CR) item.op = OP_CTRL;
        else if (addr == REG_TDR) item.op = OP_DATA;
        else item.op = OP_REG_WR;
      end
      MODE_WIN_RD: item.op = OP_WIN_RD;
      default:     item.op = OP_WIN_WR;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/core/octspi_queue.sv */
// Short request queue between the front end and the serial sequencer.
`timescale 1ns / 1ps
`default_nettype none
module octspi_queue import octspi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  item_t     wr_item,
  output logic      full,
  input  wire logic pop,
  output logic      rd_valid,
  output item_t     rd_item
);
  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  item_t         mem [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] fill;

  assign full     = (fill == CW'(QDEPTH));
  assign rd_valid = (fill != '0);
  assign rd_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop) rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + PW'(1);
      if (push && !pop) fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/octspi_back.sv */
// Serial sequencer: register file, transfer state and result generation.
`timescale 1ns / 1ps
`default_nettype none
module octspi_back import octspi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [15:0]      serial_word,
  output logic [6:0]       dummy_count,
  output logic [63:0]      read_data,
  output logic             irq_level,
  output logic             chip_select_n,
  output logic             last
);
  state_t      st, st_next, ret, ret_next;
  item_t       cur, cur_next;
  regs_t       regs, regs_next;
  xfer_t       xs, xs_next;
  logic        open_wr, open_wr_next;
  logic [31:0] open_addr, open_addr_next;
  logic [3:0]  cnt, cnt_next;

  logic        adv;
  logic        emit_en;
  logic [1:0]  e_kind;
  logic [15:0] e_word;
  logic [6:0]  e_dummy;
  logic [63:0] e_data;
  logic        e_last;

  logic [30:0] fr;
  logic [23:0] code;
  logic [1:0]  lw_log;
  logic [2:0]  shamt;
  logic [9:0]  cyc_bits;
  logic [6:0]  dbytes;
  logic [1:0]  nb_m1;
  logic        has_hi;
  state_t      p_dummy, p_opt, p_addr, p_instr, p_first;
  logic        ready;
  logic        prot;
  logic [31:0] v;
  logic [63:0] nmask;

  assign adv = !out_valid || !out_stall;
  assign fr  = regs.instr_frame;
  assign code = open_wr ? regs.write_instr_code : regs.read_instr_code;
  assign v   = cur.wdata[31:0];

  always_comb begin
    unique case (fr[3:0])
      4'd3, 4'd5: lw_log = 2'd1;
      4'd4, 4'd6: lw_log = 2'd2;
      4'd8, 4'd9: lw_log = 2'd3;
      default:    lw_log = 2'd0;
    endcase
  end

  assign shamt    = {1'b0, lw_log} + {2'b0, fr[FR_DDREN]};
  assign cyc_bits = {4'd0, fr[21:16]} << shamt;
  assign dbytes   = 7'((cyc_bits + 10'd7) >> 3);
  assign nb_m1    = fr[11:10];
  assign has_hi   = fr[FR_INSTEN] && (fr[30:28] == 3'd2 || fr[30:28] == 3'd3);

  assign p_dummy = (dbytes != '0) ? S_DUMMY : ret;
  assign p_opt   = fr[FR_OPTEN] ? S_OPT : p_dummy;
  assign p_addr  = fr[FR_ADDREN] ? S_ADDR : p_opt;
  assign p_instr = fr[FR_INSTEN] ? S_INSTR : p_addr;
  assign p_first = has_hi ? S_IHI : p_instr;

  assign ready = regs.enabled && regs.mode_reg[0] && fr[FR_DATAEN];
  assign nmask = (cur.n >= 4'd8) ? '1 : ((64'd1 << {cur.n, 3'b000}) - 64'd1);

  always_comb begin
    unique case (cur.addr)
      REG_CR:                 prot = regs.protect_mode[2];
      REG_IER, REG_IDR:       prot = regs.protect_mode[1];
      REG_MR, REG_SCFG, REG_IAR, REG_WICR, REG_IFR, REG_RICR, REG_SMR, REG_SKR,
      REG_REFRESH, REG_WRACNT, REG_TOUT:
                              prot = regs.protect_mode[0];
      default:                prot = 1'b0;
    endcase
  end

  always_comb begin
    st_next = st;
    ret_next = ret;
    cur_next = cur;
    regs_next = regs;
    xs_next = xs;
    open_wr_next = open_wr;
    open_addr_next = open_addr;
    cnt_next = cnt;
    q_pop = 1'b0;
    emit_en = 1'b0;
    e_kind = KIND_BYTE;
    e_word = '0;
    e_dummy = '0;
    e_data = '0;
    e_last = 1'b0;
    unique case (st)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cur_next = q_item;
          cnt_next = '0;
          st_next = S_EXEC;
        end
      end
      S_EXEC: begin
        st_next = S_FINAL;
        if ((cur.op == OP_CTRL || cur.op == OP_DATA || cur.op == OP_REG_WR) && prot) begin
          regs_next.protect_status = {cur.addr[7:0], 8'h01};
          cur_next.op = OP_NOP;
        end else begin
          unique case (cur.op)
            OP_CTRL: begin
              if (v[7]) begin
                regs_next = '0;
                xs_next = '0;
                cur_next.op = OP_NOP;
              end else begin
                if (v[1]) begin
                  xs_next = end_xfer(xs);
                  regs_next.enabled = 1'b0;
                end else if (v[0]) begin
                  regs_next.enabled = 1'b1;
                  xs_next.status = xs_next.status | ST_TDRE | ST_TXEMPTY | ST_RFRSHD;
                end
                if (v[5]) xs_next.status = xs_next.status | ST_RFRSHD;
                if (v[10]) xs_next.status = xs_next.status & ~ST_TOUT;
                if (v[9]) begin
                  open_wr_next = !fr[FR_APBRD];
                  open_addr_next = regs.instr_address;
                  ret_next = S_FINAL;
                  st_next = S_OPEN;
                end
              end
            end
            OP_DATA: begin
              if (!xs.active) begin
                open_wr_next = 1'b1;
                open_addr_next = regs.instr_address;
                ret_next = S_WORD;
                st_next = S_OPEN;
              end else begin
                st_next = S_WORD;
              end
            end
            OP_WIN_RD: begin
              if (ready) begin
                st_next = S_DATA;
                if (!xs.active || regs.is_write ||
                    (fr[FR_ADDREN] && regs.next_address != cur.off)) begin
                  open_wr_next = 1'b0;
                  open_addr_next = cur.off;
                  ret_next = S_DATA;
                  st_next = S_OPEN;
                end
              end
            end
            OP_WIN_WR: begin
              if (ready) begin
                st_next = S_DATA;
                if (!xs.active || !regs.is_write ||
                    (fr[FR_ADDREN] && regs.next_address != cur.off)) begin
                  open_wr_next = 1'b1;
                  open_addr_next = cur.off;
                  ret_next = S_DATA;
                  st_next = S_OPEN;
                end
              end
            end
            default: st_next = S_FINAL;
          endcase
        end
      end
      S_OPEN: begin
        if (xs.active) xs_next = end_xfer(xs);
        if (!xs_next.cs) begin
          xs_next.cs = 1'b1;
          xs_next.status = xs_next.status | ST_CSFA;
        end
        xs_next.active = 1'b1;
        xs_next.count = '0;
        regs_next.is_write = open_wr;
        regs_next.next_address = open_addr;
        st_next = p_first;
        if (p_first == S_ADDR) cnt_next = {2'b00, nb_m1};
      end
      S_IHI: begin
        if (adv) begin
          emit_en = 1'b1;
          e_word = {8'h00, code[15:8]};
          st_next = S_INSTR;
        end
      end
      S_INSTR: begin
        if (adv) begin
          emit_en = 1'b1;
          e_word = {8'h00, code[7:0]};
          st_next = p_addr;
          if (p_addr == S_ADDR) cnt_next = {2'b00, nb_m1};
        end
      end
      S_ADDR: begin
        if (adv) begin
          emit_en = 1'b1;
          e_word = {8'h00, 8'(open_addr >> {cnt[1:0], 3'b000})};
          if (cnt == '0) st_next = p_opt;
          else cnt_next = cnt - 4'd1;
        end
      end
      S_OPT: begin
        if (adv) begin
          emit_en = 1'b1;
          e_word = {8'h00, code[23:16]};
          st_next = p_dummy;
        end
      end
      S_DUMMY: begin
        if (adv) begin
          emit_en = 1'b1;
          e_kind = KIND_DUMMY;
          e_dummy = dbytes;
          st_next = ret;
        end
      end
      S_WORD: begin
        if (adv) begin
          emit_en = 1'b1;
          e_word = v[15:0];
          st_next = S_FINAL;
        end
      end
      S_DATA: begin
        if (cnt == cur.n) begin
          st_next = S_FINAL;
        end else if (adv) begin
          emit_en = 1'b1;
          if (cur.op == OP_WIN_WR) e_word = {8'h00, 8'(cur.wdata >> {cnt[2:0], 3'b000})};
          cnt_next = cnt + 4'd1;
        end
      end
      S_FINAL: begin
        if (adv) begin
          emit_en = 1'b1;
          e_kind = KIND_RESP;
          e_last = 1'b1;
          st_next = S_IDLE;
          unique case (cur.op)
            OP_REG_RD: begin
              unique case (cur.addr)
                REG_MR:   e_data = 64'(regs.mode_reg);
                REG_RDR: begin
                  xs_next.status = xs.status & ~ST_RDRF;
                  e_data = 64'(regs.receive_data);
                end
                REG_SR: begin
                  xs_next.status = xs.status & ~ST_RDCLR;
                  e_data = 64'(xs.status);
                end
                REG_IMR:  e_data = 64'(regs.int_mask);
                REG_SCFG: e_data = 64'(regs.scramble_cfg);
                REG_SR2: begin
                  if (regs.enabled) e_data = xs.cs ? 64'h2 : 64'h16;
                end
                REG_IAR:     e_data = 64'(regs.instr_address);
                REG_WICR:    e_data = 64'(regs.write_instr_code);
                REG_IFR:     e_data = 64'(regs.instr_frame);
                REG_RICR:    e_data = 64'(regs.read_instr_code);
                REG_SMR:     e_data = 64'(regs.scramble_mode);
                REG_REFRESH: e_data = 64'(regs.refresh_reg);
                REG_WRACNT:  e_data = 64'(regs.write_access_limit);
                REG_TOUT:    e_data = 64'(regs.timeout_reg);
                REG_WPMR:    e_data = 64'(regs.protect_mode);
                REG_WPSR: begin
                  e_data = 64'(regs.protect_status);
                  regs_next.protect_status = '0;
                end
                default: e_data = '0;
              endcase
            end
            OP_REG_WR: begin
              unique case (cur.addr)
                REG_MR:   regs_next.mode_reg = v & MR_MASK;
                REG_IER:  regs_next.int_mask = regs.int_mask | (v[17:0] & ST_ALL);
                REG_IDR:  regs_next.int_mask = regs.int_mask & ~(v[17:0] & ST_ALL);
                REG_SCFG: regs_next.scramble_cfg = v & SCFG_MASK;
                REG_IAR:  regs_next.instr_address = v;
                REG_WICR: regs_next.write_instr_code = v[23:0];
                REG_IFR:  regs_next.instr_frame = v[30:0] & IFR_MASK[30:0];
                REG_RICR: regs_next.read_instr_code = v[23:0];
                REG_SMR: begin
                  if (regs.scramble_mode[2]) regs_next.scramble_mode = {1'b1, v[1:0]};
                  else regs_next.scramble_mode = v[2:0];
                end
                REG_SKR: begin
                  if (!regs.scramble_mode[2]) regs_next.scramble_key = v;
                end
                REG_REFRESH: regs_next.refresh_reg = v;
                REG_WRACNT:  regs_next.write_access_limit = v;
                REG_TOUT:    regs_next.timeout_reg = v[15:0];
                REG_WPMR: begin
                  if (v[31:8] == WP_KEY) regs_next.protect_mode = v[2:0];
                end
                default: ;
              endcase
            end
            OP_CTRL: begin
              if ((v[9] && !fr[FR_DATAEN]) || v[24]) xs_next = end_xfer(xs);
            end
            OP_DATA: begin
              regs_next.receive_data = cur.rx[15:0];
              xs_next.status = xs.status | ST_RDRF | ST_TDRE | ST_TXEMPTY;
            end
            OP_WIN_RD: begin
              if (ready) begin
                e_data = cur.rx & nmask;
                regs_next.next_address = cur.off + 32'(cur.n);
                xs_next.count = xs.count + 32'(cur.n);
              end else begin
                e_data = nmask;
              end
            end
            OP_WIN_WR: begin
              if (ready) begin
                regs_next.next_address = cur.off + 32'(cur.n);
                xs_next.count = xs.count + 32'(cur.n);
                if (regs.write_access_limit == '0 ||
                    xs_next.count >= regs.write_access_limit)
                  xs_next.status = xs_next.status | ST_LWRA;
              end
            end
            default: ;
          endcase
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    open_wr <= open_wr_next;
    open_addr <= open_addr_next;
    if (emit_en) begin
      kind <= e_kind;
      serial_word <= e_word;
      dummy_count <= e_dummy;
      read_data <= e_data;
      last <= e_last;
      irq_level <= |(xs_next.status & regs_next.int_mask);
      chip_select_n <= !xs_next.cs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ret <= S_IDLE;
      cnt <= '0;
      regs <= '0;
      xs <= '0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      ret <= ret_next;
      cnt <= cnt_next;
      regs <= regs_next;
      xs <= xs_next;
      if (emit_en) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/octal_spi_flash_controller.sv */
// Top level of the octal serial flash controller: front end, queue and sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Each bus request (register read/write or memory window read/write) yields a
// stream of results that may hold serial bytes for instruction, address and
// option phases, at most one dummy-run result and data bytes, and that ends
// in a closing response flagged by last. Requests pass a classifying front end
// into a two-entry queue; the serial sequencer produces at most one result per
// cycle, none while the output is stalled. Opening a new transfer adds an open
// step; the sequencer is the limiting unit and handles one request at a time.
module octal_spi_flash_controller import octspi_pkg::*; #(
  parameter int WINDOW_ADDR_BITS = WINDOW_ADDR_BITS_DEF,
  parameter int MAX_ACCESS_BYTES = MAX_ACCESS_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [28:0] addr,
  input  wire logic [63:0] wdata,
  input  wire logic [3:0]  size,
  input  wire logic [63:0] rx_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [15:0]      serial_word,
  output logic [6:0]       dummy_count,
  output logic [63:0]      read_data,
  output logic             irq_level,
  output logic             chip_select_n,
  output logic             last
);
  item_t f_item;
  item_t q_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  assign in_stall = q_full;

  octspi_front #(
    .WINDOW_ADDR_BITS(WINDOW_ADDR_BITS),
    .MAX_ACCESS_BYTES(MAX_ACCESS_BYTES)
  ) u_front (
    .mode(mode), .addr(addr), .wdata(wdata), .size(size), .rx_data(rx_data),
    .item(f_item)
  );

  octspi_queue u_queue (
    .clk(clk), .rst(rst), .push(in_valid && !q_full), .wr_item(f_item),
    .full(q_full), .pop(q_pop), .rd_valid(q_valid), .rd_item(q_item)
  );

  octspi_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .serial_word(serial_word), .dummy_count(dummy_count), .read_data(read_data),
    .irq_level(irq_level), .chip_select_n(chip_select_n), .last(last)
  );
endmodule
`default_nettype wire

/* rtl/core/octspi_checker.sv */
// Port-level checks on the controller's result stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module octspi_checker import octspi_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] kind,
  input wire logic [6:0] dummy_count,
  input wire logic       chip_select_n,
  input wire logic       last
);
  a_last_on_resp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == KIND_RESP)))
    else $error("last does not match response kind");

  a_dummy_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_DUMMY) |-> (dummy_count != 7'd0))
    else $error("empty dummy run");

  a_cs_on_serial: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_RESP) |-> !chip_select_n)
    else $error("serial traffic without chip select");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(last)))
    else $error("stalled result changed");
endmodule

bind octal_spi_flash_controller octspi_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
  .dummy_count(dummy_count), .chip_select_n(chip_select_n), .last(last)
);
`default_nettype wire

/* sim/tb_octal_spi_flash_controller.sv */
// Self-checking testbench for the octal serial flash controller top level.
`timescale 1ns / 1ps
module tb_octal_spi_flash_controller;
  import octspi_pkg::*;

  localparam logic [31:0] CR_EN         = 32'h1;
  localparam logic [31:0] CR_DIS        = 32'h2;
  localparam logic [31:0] CR_UPDREF     = 32'h20;
  localparam logic [31:0] CR_SOFT_RESET = 32'h80;
  localparam logic [31:0] CR_START      = 32'h200;
  localparam logic [31:0] CR_TOCLR      = 32'h400;
  localparam logic [31:0] CR_LAST       = 32'h1000000;
  localparam int          RES_CAP       = 17;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word;
    logic [6:0]  dummy;
    logic [63:0] data;
    logic        irq;
    logic        csn;
    logic        last;
  } flash_result_t;

  class flash_scoreboard;
    logic [31:0] mode_reg, scramble_cfg, instr_address, scramble_key;
    logic [31:0] refresh_reg, write_access_limit, next_address, byte_count;
    logic [17:0] int_status, int_mask;
    logic [23:0] write_code, read_code;
    logic [30:0] frame;
    logic [2:0]  scramble_mode, protect_mode;
    logic [15:0] timeout_reg, protect_status, receive_data;
    logic        enabled, cs_on, active, is_write;
    flash_result_t expected_results[$];
    int n_emitted, errors, matched, requests;

    function void clear_all();
      mode_reg = 0; scramble_cfg = 0; instr_address = 0; scramble_key = 0;
      refresh_reg = 0; write_access_limit = 0; next_address = 0; byte_count = 0;
      int_status = 0; int_mask = 0; write_code = 0; read_code = 0; frame = 0;
      scramble_mode = 0; protect_mode = 0; timeout_reg = 0; protect_status = 0;
      receive_data = 0; enabled = 0; cs_on = 0; active = 0; is_write = 0;
    endfunction

    function void emit(logic [1:0] k, logic [15:0] w, logic [6:0] d, logic [63:0] data,
                       logic lst);
      flash_result_t r;
      if (n_emitted >= RES_CAP) return;
      r.kind = k; r.word = w; r.dummy = d; r.data = data;
      r.irq = |(int_status & int_mask); r.csn = !cs_on; r.last = lst;
      expected_results.push_back(r);
      n_emitted++;
    endfunction

    function void set_cs(logic on);
      if (cs_on == on) return;
      cs_on = on;
      int_status |= on ? ST_CSFA : (ST_CSR | ST_CSRA);
    endfunction

    function void end_xfer();
      if (active || cs_on) begin
        int_status |= ST_INSTRE;
        set_cs(1'b0);
      end
      active = 0;
      byte_count = 0;
    endfunction

    function logic [31:0] lanes();
      case (frame[3:0])
        4'd3, 4'd5: return 2;
        4'd4, 4'd6: return 4;
        4'd8, 4'd9: return 8;
        default: return 1;
      endcase
    endfunction

    function void begin_xfer(logic wr, logic [31:0] a);
      logic [23:0] code;
      logic [31:0] nb, dbytes;
      code = wr ? write_code : read_code;
      if (active) end_xfer();
      set_cs(1'b1);
      if (frame[FR_INSTEN]) begin
        if (frame[30:28] == 3'd2 || frame[30:28] == 3'd3) emit(KIND_BYTE, code[15:8], 0, 0, 0);
        emit(KIND_BYTE, code[7:0], 0, 0, 0);
      end
      if (frame[FR_ADDREN]) begin
        nb = frame[11:10] + 1;
        for (int i = nb - 1; i >= 0; i--) emit(KIND_BYTE, (a >> (8 * i)) & 8'hff, 0, 0, 0);
      end
      if (frame[FR_OPTEN]) emit(KIND_BYTE, code[23:16], 0, 0, 0);
      dbytes = (frame[21:16] * lanes() * (frame[FR_DDREN] ? 2 : 1) + 7) / 8;
      if (dbytes != 0) emit(KIND_DUMMY, 0, dbytes[6:0], 0, 0);
      active = 1;
      is_write = wr;
      byte_count = 0;
      next_address = a;
    endfunction

    function logic is_protected(logic [28:0] off);
      if (protect_mode[2] && off == REG_CR) return 1;
      if (protect_mode[1] && (off == REG_IER || off == REG_IDR)) return 1;
      if (!protect_mode[0]) return 0;
      case (off)
        REG_MR, REG_SCFG, REG_IAR, REG_WICR, REG_IFR, REG_RICR, REG_SMR, REG_SKR,
        REG_REFRESH, REG_WRACNT, REG_TOUT: return 1;
        default: return 0;
      endcase
    endfunction

    function logic [63:0] reg_read(logic [28:0] off);
      logic [31:0] v;
      v = 0;
      case (off)
        REG_MR: v = mode_reg;
        REG_RDR: begin
          int_status &= ~ST_RDRF;
          v = receive_data;
        end
        REG_SR: begin
          v = int_status;
          int_status &= ~ST_RDCLR;
        end
        REG_IMR: v = int_mask;
        REG_SCFG: v = scramble_cfg;
        REG_SR2: if (enabled) v = cs_on ? 32'h2 : 32'h16;
        REG_IAR: v = instr_address;
        REG_WICR: v = write_code;
        REG_IFR: v = frame;
        REG_RICR: v = read_code;
        REG_SMR: v = scramble_mode;
        REG_REFRESH: v = refresh_reg;
        REG_WRACNT: v = write_access_limit;
        REG_TOUT: v = timeout_reg;
        REG_WPMR: v = protect_mode;
        REG_WPSR: begin
          v = protect_status;
          protect_status = 0;
        end
        default: v = 0;
      endcase
      return {32'h0, v};
    endfunction

    function void reg_write(logic [28:0] off, logic [31:0] v, logic [63:0] rx);
      if (is_protected(off)) begin
        protect_status = {off[7:0], 8'h01};
        return;
      end
      case (off)
        REG_CR: begin
          if (v & CR_SOFT_RESET) begin
            end_xfer();
            clear_all();
          end else begin
            if (v & CR_DIS) begin
              end_xfer();
              enabled = 0;
            end else if (v & CR_EN) begin
              enabled = 1;
              int_status |= ST_TDRE | ST_TXEMPTY | ST_RFRSHD;
            end
            if (v & CR_UPDREF) int_status |= ST_RFRSHD;
            if (v & CR_TOCLR) int_status &= ~ST_TOUT;
            if (v & CR_START) begin
              begin_xfer(!frame[FR_APBRD], instr_address);
              if (!frame[FR_DATAEN]) end_xfer();
            end
            if (v & CR_LAST) end_xfer();
          end
        end
        REG_MR: mode_reg = v & MR_MASK;
        REG_TDR: begin
          if (!active) begin_xfer(1'b1, instr_address);
          emit(KIND_BYTE, v[15:0], 0, 0, 0);
          receive_data = rx[15:0];
          int_status |= ST_RDRF | ST_TDRE | ST_TXEMPTY;
        end
        REG_IER: int_mask |= v[17:0] & ST_ALL;
        REG_IDR: int_mask &= ~(v[17:0] & ST_ALL);
        REG_SCFG: scramble_cfg = v & SCFG_MASK;
        REG_IAR: instr_address = v;
        REG_WICR: write_code = v[23:0];
        REG_IFR: frame = v[30:0] & IFR_MASK[30:0];
        REG_RICR: read_code = v[23:0];
        REG_SMR: scramble_mode = scramble_mode[2] ? {1'b1, v[1:0]} : v[2:0];
        REG_SKR: if (!scramble_mode[2]) scramble_key = v;
        REG_REFRESH: refresh_reg = v;
        REG_WRACNT: write_access_limit = v;
        REG_TOUT: timeout_reg = v[15:0];
        REG_WPMR: if (v[31:8] == WP_KEY) protect_mode = v[2:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] m, logic [28:0] a, logic [63:0] wd,
                               logic [3:0] sz, logic [63:0] rx);
      logic [63:0] data;
      logic [31:0] off, n;
      logic ready;
      n_emitted = 0;
      requests++;
      data = 0;
      if (m == MODE_REG_RD) begin
        data = reg_read(a);
        emit(KIND_RESP, 0, 0, data, 1);
        return;
      end
      if (m == MODE_REG_WR) begin
        reg_write(a, wd[31:0], rx);
        emit(KIND_RESP, 0, 0, 0, 1);
        return;
      end
      off = {3'b0, a};
      n = sz > MAX_ACCESS_BYTES_DEF ? MAX_ACCESS_BYTES_DEF : sz;
      ready = enabled && mode_reg[0] && frame[FR_DATAEN];
      if (m == MODE_WIN_RD) begin
        if (!ready) begin
          data = n >= 8 ? '1 : ((64'd1 << (8 * n)) - 1);
        end else begin
          if (!active || is_write || (frame[FR_ADDREN] && next_address != off))
            begin_xfer(1'b0, off);
          for (int i = 0; i < n; i++) begin
            emit(KIND_BYTE, 0, 0, 0, 0);
            data[8*i +: 8] = rx[8*i +: 8];
          end
          next_address = off + n;
          byte_count += n;
        end
        emit(KIND_RESP, 0, 0, data, 1);
        return;
      end
      if (ready) begin
        if (!active || !is_write || (frame[FR_ADDREN] && next_address != off))
          begin_xfer(1'b1, off);
        for (int i = 0; i < n; i++) emit(KIND_BYTE, wd[8*i +: 8], 0, 0, 0);
        next_address = off + n;
        byte_count += n;
        if (write_access_limit == 0 || byte_count >= write_access_limit)
          int_status |= ST_LWRA;
      end
      emit(KIND_RESP, 0, 0, 0, 1);
    endfunction

    function void check_result(flash_result_t got);
      flash_result_t exp_r;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  mode = 0;
  logic [28:0] addr = 0;
  logic [63:0] wdata = 0;
  logic [3:0]  size = 0;
  logic [63:0] rx_data = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  kind;
  logic [15:0] serial_word;
  logic [6:0]  dummy_count;
  logic [63:0] read_data;
  logic        irq_level, chip_select_n, last;

  flash_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int long_holds = 0;

  octal_spi_flash_controller i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .addr(addr), .wdata(wdata), .size(size), .rx_data(rx_data),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .serial_word(serial_word), .dummy_count(dummy_count), .read_data(read_data),
    .irq_level(irq_level), .chip_select_n(chip_select_n), .last(last)
  );

  always #5 clk = ~clk;

  // receiver stall, with a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
      long_holds++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({kind, serial_word, dummy_count, read_data, irq_level,
                       chip_select_n, last});
  end

  task automatic send(logic [1:0] m, logic [28:0] a, logic [63:0] wd, logic [3:0] sz,
                      logic [63:0] rx);
    in_valid <= 1'b1;
    mode <= m; addr <= a; wdata <= wd; size <= sz; rx_data <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(m, a, wd, sz, rx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [28:0] pick_reg();
    logic [28:0] regs[21] = '{REG_CR, REG_MR, REG_RDR, REG_TDR, REG_SR, REG_IER, REG_IDR,
                              REG_IMR, REG_SCFG, REG_SR2, REG_IAR, REG_WICR, REG_IFR,
                              REG_RICR, REG_SMR, REG_SKR, REG_REFRESH, REG_WRACNT,
                              REG_TOUT, REG_WPMR, REG_WPSR};
    return regs[$urandom_range(20)];
  endfunction

  task automatic reg_wr(logic [28:0] a, logic [31:0] v);
    send(MODE_REG_WR, a, {$urandom, v}, 4'd4, rand64());
  endtask

  task automatic rand_request();
    int r;
    logic [31:0] v;
    logic [28:0] a;
    r = $urandom_range(99);
    if (r < 8) begin
      // keep the data path usable most of the time
      reg_wr(REG_CR, CR_EN | ($urandom_range(3) == 0 ? CR_UPDREF | CR_TOCLR : 0));
      reg_wr(REG_MR, $urandom | 32'h1);
    end else if (r < 16) begin
      v = $urandom;
      v[FR_DATAEN] = ($urandom_range(9) != 0);
      if ($urandom_range(2) != 0) v[21:16] = $urandom_range(3);
      reg_wr(REG_IFR, v);
    end else if (r < 24) begin
      a = pick_reg();
      v = $urandom;
      if (a == REG_CR) v = $urandom_range(19) == 0 ? CR_SOFT_RESET : (v & ~CR_SOFT_RESET);
      if (a == REG_WPMR) v = {($urandom_range(3) == 0 ? 24'(v[31:8]) : WP_KEY),
                              5'(v[7:3]), ($urandom_range(1) ? 3'b0 : 3'(v[2:0]))};
      if (a == REG_WRACNT) v = $urandom_range(40);
      reg_wr(a, v);
    end else if (r < 34) begin
      send(MODE_REG_RD, $urandom_range(9) == 0 ? 29'($urandom) : pick_reg(), rand64(),
           4'($urandom), rand64());
    end else if (r < 38) begin
      send(2'($urandom), 29'($urandom_range(255)), rand64(), 4'($urandom), rand64());
    end else begin
      // window access, often sequential so the open transfer continues
      a = ($urandom_range(1) && sb.next_address[31:29] == 0) ? sb.next_address[28:0]
                                                              : 29'($urandom);
      send($urandom_range(1) ? MODE_WIN_RD : MODE_WIN_WR, a, rand64(),
           $urandom_range(4) == 0 ? 4'($urandom) : 4'($urandom_range(1, 8)), rand64());
    end
  endtask

  initial begin
    #3_000_000;
    $display("tb_octal_spi_flash_controller: done, errors");
    $finish;
  end

  initial begin
    int waited;
    sb.clear_all();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send(MODE_WIN_RD, 29'h1234, '0, 4'd3, rand64());
    send(MODE_WIN_RD, 29'h0, '0, 4'd0, rand64());
    send(MODE_REG_RD, REG_TDR, '0, 4'd4, '0);
    reg_wr(REG_CR, CR_EN);
    reg_wr(REG_MR, 32'h1);
    reg_wr(REG_IFR, 32'h203f8cf9);
    reg_wr(REG_WICR, 32'hffffff);
    reg_wr(REG_RICR, 32'ha5b6c7);
    send(MODE_WIN_WR, 29'h1fffffff, '1, 4'd8, '0);
    send(MODE_WIN_WR, 29'h1fffffff, 64'h0123456789abcdef, 4'd15, '1);
    send(MODE_WIN_RD, 29'h0, '0, 4'd8, 64'hfedcba9876543210);
    send(MODE_WIN_RD, 29'h8, '0, 4'd0, '1);
    reg_wr(REG_IFR, 32'hf0);
    send(MODE_WIN_RD, 29'h40, '0, 4'd2, '1);
    reg_wr(REG_TDR, 32'hbeef);
    send(MODE_REG_RD, REG_SR, '0, 4'd4, '0);
    send(MODE_REG_RD, REG_RDR, '0, 4'd4, '0);
    reg_wr(29'h1f0, '1);
    reg_wr(REG_SR, '1);
    reg_wr(REG_WPMR, {WP_KEY, 8'h07});
    reg_wr(REG_MR, '1);
    send(MODE_REG_RD, REG_WPSR, '0, 4'd4, '0);
    reg_wr(REG_CR, CR_START | CR_LAST | CR_EN);
    reg_wr(REG_WPMR, {WP_KEY, 8'h00});
    reg_wr(REG_SMR, 32'h4);
    reg_wr(REG_SKR, '1);
    reg_wr(REG_IER, ST_ALL);
    reg_wr(REG_CR, CR_SOFT_RESET);

    // random, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 10 : (ph == 1 ? 64 : 0);
      recv_idle_pct = ph == 0 ? 64 : (ph == 1 ? 10 : 0);
      for (int k = 0; k < 130; k++) begin
        if (ph == 2 && k == 20) hold_req = 300;
        rand_request();
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (sb.expected_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (sb.expected_results.size() != 0) sb.errors++;
    $display("covered %0d requests, %0d results matched, %0d long output hold-offs",
             sb.requests, sb.matched, long_holds);
    $display("mismatches %0d, results still outstanding %0d",
             sb.errors, sb.expected_results.size());
    if (sb.errors == 0) begin
      $display("tb_octal_spi_flash_controller: done, clean");
    end else begin
      $display("tb_octal_spi_flash_controller: done, errors");
    end
    $finish;
  end
endmodule
